### design/tspsa_pkg.sv
// types and constants shared by the transport-stream sync lock block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tspsa_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned GAP_W    = 8;
  localparam int unsigned RUN_W    = 16;
  localparam int unsigned KEEP_W   = 11;
  localparam int unsigned THRESH_W = 16;

  localparam logic [BYTE_W-1:0]   SYNC_BYTE    = 8'h47;
  localparam logic [RUN_W-1:0]    RUN_MAX      = 16'hFFFF;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd800;

  // one result item as it leaves the tracker
  typedef struct packed {
    logic [KEEP_W-1:0] keep_count;
    logic              lock_now;
    logic [BYTE_W-1:0] byte_out;
    logic              pass_out;
  } result_t;

endpackage

`default_nettype wire

### design/tspsa_tracker.sv
// sync-byte tracker: hunt / check state, run count, buffer length and lock decision
// depends on tspsa_pkg
`timescale 1ns / 1ps
`default_nettype none

module tspsa_tracker
  import tspsa_pkg::*;
#(
  parameter int unsigned PACKET_BYTES = 188,
  parameter int unsigned LEAD_PACKETS = 10
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wen,
  input  wire logic [THRESH_W-1:0] cfg_wdata,
  input  wire logic                in_fire,
  input  wire logic [BYTE_W-1:0]   data_byte,
  input  wire logic                end_of_buffer,
  output result_t                  result
);

  localparam int unsigned LEAD   = PACKET_BYTES * LEAD_PACKETS;
  localparam int unsigned BUF_W  = $clog2(LEAD + 1);
  localparam int unsigned DIFF_W = (BUF_W > KEEP_W) ? BUF_W : KEEP_W;

  logic [THRESH_W-1:0] lock_threshold;
  logic                locked,  locked_next;
  logic                hunting, hunting_next;
  logic [GAP_W-1:0]    gap_to_check, gap_to_check_next;
  logic [RUN_W-1:0]    run_count, run_count_next;
  // only whether the lead length was reached matters, so the count stops there
  logic [BUF_W-1:0]    buffer_bytes, buffer_bytes_next;
  logic                lock_now;
  logic [DIFF_W-1:0]   keep_diff;
  logic [KEEP_W-1:0]   keep_count;

  always_comb begin
    locked_next       = locked;
    hunting_next      = hunting;
    gap_to_check_next = gap_to_check;
    run_count_next    = run_count;
    buffer_bytes_next = buffer_bytes;
    lock_now          = 1'b0;
    keep_diff         = '0;
    keep_count        = '0;
    if (!locked) begin
      if (buffer_bytes != BUF_W'(LEAD)) begin
        buffer_bytes_next = buffer_bytes + BUF_W'(1);
      end
      if (hunting) begin
        if (data_byte == SYNC_BYTE) begin
          hunting_next      = 1'b0;
          gap_to_check_next = GAP_W'(PACKET_BYTES - 1);
        end
      end else if (gap_to_check != '0) begin
        gap_to_check_next = gap_to_check - GAP_W'(1);
      end else if (data_byte == SYNC_BYTE) begin
        if (run_count != RUN_MAX) begin
          run_count_next = run_count + RUN_W'(1);
        end
        gap_to_check_next = GAP_W'(PACKET_BYTES - 1);
      end else begin
        run_count_next = RUN_W'(1);
        hunting_next   = 1'b1;
      end

      if (end_of_buffer) begin
        // open hunt ends with the buffer; next check a full packet into the next one
        if (hunting_next) begin
          hunting_next      = 1'b0;
          gap_to_check_next = GAP_W'(PACKET_BYTES);
        end
        if (run_count_next >= lock_threshold && buffer_bytes_next == BUF_W'(LEAD)) begin
          locked_next       = 1'b1;
          lock_now          = 1'b1;
          keep_diff         = DIFF_W'(LEAD) - DIFF_W'(gap_to_check_next);
          keep_count        = keep_diff[KEEP_W-1:0];
          run_count_next    = '0;
          gap_to_check_next = '0;
        end
        buffer_bytes_next = '0;
      end
    end
  end

  always_comb begin
    result.pass_out   = locked;
    result.byte_out   = data_byte;
    result.lock_now   = lock_now;
    result.keep_count = keep_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_threshold <= THRESH_RESET;
    end else if (cfg_wen) begin
      lock_threshold <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      locked       <= 1'b0;
      hunting      <= 1'b0;
      gap_to_check <= '0;
      run_count    <= RUN_W'(1);
      buffer_bytes <= '0;
    end else if (in_fire) begin
      locked       <= locked_next;
      hunting      <= hunting_next;
      gap_to_check <= gap_to_check_next;
      run_count    <= run_count_next;
      buffer_bytes <= buffer_bytes_next;
    end
  end

endmodule

`default_nettype wire

### design/tspsa_out_buf.sv
// two-entry result queue that decouples the output side from the input side
// depends on tspsa_pkg
`timescale 1ns / 1ps
`default_nettype none

module tspsa_out_buf
  import tspsa_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         not_full,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  result_t     entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;

  assign pop       = out_valid && out_ready;
  assign not_full  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### design/ts_packet_sync_acquire_core.sv
// top level of the transport-stream sync-byte lock block
// depends on tspsa_pkg, tspsa_tracker, tspsa_out_buf
`timescale 1ns / 1ps
`default_nettype none

// Takes one transport-stream byte per transfer, with tlast on the last byte of
// each delivered buffer, and gives one result per byte: the byte echoed, a pass
// flag once the stream is locked, and at the buffer end where lock is reached
// a lock flag with the count of trailing bytes to forward. A byte is taken in
// every cycle while the queue has room: the tracker updates its whole state on
// each transfer, and its result goes into a two-entry output queue, so the
// result appears in the cycle after the transfer. Input is held off only while both
// queue entries wait on the output side. The user must write lock_threshold through
// cfg_wen / cfg_wdata only while no byte is in flight; the block does not enforce it.
module ts_packet_sync_acquire_core
  import tspsa_pkg::*;
#(
  parameter int unsigned PACKET_BYTES = 188,
  parameter int unsigned LEAD_PACKETS = 10
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wen,
  input  wire logic [THRESH_W-1:0] cfg_wdata,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,   // data_byte[7:0]
  input  wire logic                s_axis_tlast,   // end_of_buffer
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [23:0]              m_axis_tdata,   // byte_out[7:0], keep_count[18:8], zero pad
  output logic [1:0]               m_axis_tuser    // pass_out[0], lock_now[1]
);

  logic    in_fire;
  logic    buf_not_full;
  result_t result;
  result_t out_result;

  assign s_axis_tready = buf_not_full;
  assign in_fire       = s_axis_tvalid && buf_not_full;

  tspsa_tracker #(
    .PACKET_BYTES (PACKET_BYTES),
    .LEAD_PACKETS (LEAD_PACKETS)
  ) u_tracker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .in_fire       (in_fire),
    .data_byte     (s_axis_tdata),
    .end_of_buffer (s_axis_tlast),
    .result        (result)
  );

  tspsa_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire),
    .push_data (result),
    .not_full  (buf_not_full),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_result)
  );

  assign m_axis_tdata = {5'b0, out_result.keep_count, out_result.byte_out};
  assign m_axis_tuser = {out_result.lock_now, out_result.pass_out};

endmodule

`default_nettype wire

### design/tspsa_checker.sv
// port-level checks for the sync lock block, bound to the top level
// depends on ts_packet_sync_acquire_core
`timescale 1ns / 1ps
`default_nettype none

module tspsa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // lock is only reported on a byte taken before the block was locked
  a_lock_not_passed: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
    else $error("lock reported on a passed byte");

  // keep count carries a value only with the lock flag
  a_keep_only_on_lock: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[18:8] == 11'd0)
    else $error("keep count without lock");

  // an empty output side never holds off input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with nothing waiting");

  // a transfer taken shows a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("no result after input transfer");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind ts_packet_sync_acquire_core tspsa_checker u_tspsa_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
